### rtl/core/abifc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// abifc_pkg
// Types and constants for the adaptive burst/interval send pacer.
// ----------------------------------------------------------------------------
package abifc_pkg;

  // Request codes carried by req_type
  typedef enum logic [1:0] {
    REQ_DEC   = 2'd0,
    REQ_INC   = 2'd1,
    REQ_YIELD = 2'd2,
    REQ_LINK  = 2'd3
  } req_t;

  // Result codes carried by action
  typedef enum logic [2:0] {
    ACT_NONE  = 3'd0,
    ACT_DEC   = 3'd1,
    ACT_INC   = 3'd2,
    ACT_YIELD = 3'd3
  } action_t;

  // Configuration register indexes
  localparam logic REG_USAGE_LIMIT = 1'b0;
  localparam logic [6:0] USAGE_LIMIT_RST = 7'd80;

  // Link count clamp
  localparam logic [7:0] MAX_LINKS = 8'd63;

  // Burst and interval bounds
  localparam logic [6:0]  RESET_BURST_LIMIT = 7'd12;
  localparam logic [6:0]  MIN_BURST         = 7'd2;
  localparam logic [6:0]  START_BURST       = 7'd4;
  localparam logic [15:0] MAX_INTERVAL      = 16'd50000;
  localparam logic [15:0] MIN_INTERVAL      = 16'd5000;
  localparam logic [15:0] START_INTERVAL    = 16'd10000;

  // Hold-off times in seconds
  localparam logic [31:0] HOLD_INC      = 32'd6;
  localparam logic [31:0] HOLD_DEC      = 32'd2;
  localparam logic [31:0] HOLD_CONGEST  = 32'd15;
  localparam logic [31:0] HOLD_OVERLOAD = 32'd5;
  localparam logic [31:0] HOLD_YIELD    = 32'd10;

  // Load margins around usage_limit (percent)
  localparam logic [7:0] MARGIN_OVERLOAD = 8'd6;
  localparam logic [7:0] MARGIN_HIGH     = 8'd3;
  localparam logic [7:0] MARGIN_BUSY     = 8'd4;
  localparam logic [7:0] MARGIN_NEAR     = 8'd5;
  localparam logic [7:0] MARGIN_YIELD    = 8'd10;

  // Q16 factors
  localparam logic [16:0] Q_UP    = 17'd71434;
  localparam logic [15:0] Q_DOWN  = 16'd63570;
  localparam logic [15:0] Q_FLOOR = 16'd52429;

endpackage
`default_nettype wire

### rtl/core/abifc_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// abifc_if
// Valid/ready channels for pacer events and pacer results.
// ----------------------------------------------------------------------------
interface abifc_evt_if;
  logic        valid;
  logic        ready;
  logic [1:0]  req_type;
  logic [31:0] now_sec;
  logic [19:0] sent_count;
  logic [6:0]  load_pct;
  logic [5:0]  active_links;

  modport source (output valid, req_type, now_sec, sent_count, load_pct, active_links,
                  input ready);
  modport sink   (input valid, req_type, now_sec, sent_count, load_pct, active_links,
                  output ready);
endinterface

interface abifc_res_if;
  logic        valid;
  logic        ready;
  logic [2:0]  action;
  logic [6:0]  burst_size;
  logic [15:0] burst_interval;
  logic [19:0] target_rate;
  logic [19:0] peak_rate;

  modport source (output valid, action, burst_size, burst_interval, target_rate, peak_rate,
                  input ready);
  modport sink   (input valid, action, burst_size, burst_interval, target_rate, peak_rate,
                  output ready);
endinterface
`default_nettype wire

### rtl/core/adaptive_burst_interval_flow_control.sv
`timescale 1ns / 1ps
`default_nettype none
// An event transaction is captured in the input register, then the state update is
// captured in the result register; a stalled result holds the input register.
// Throughput: one event per cycle while results are taken, set by the combinational
// state update between the two registers.
// Reset (synchronous, rst high): pacing state returns to its start values,
// usage_limit to 80, both stages empty.
// ----------------------------------------------------------------------------
// adaptive_burst_interval_flow_control
// Signalling-link send pacer: steps burst size and inter-burst interval per event.
// ----------------------------------------------------------------------------
module adaptive_burst_interval_flow_control (
  input  wire logic        clk,
  input  wire logic        rst,
  abifc_evt_if.sink        evt,
  abifc_res_if.source      res,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  // --------------------------------------------------------------------------
  // Configuration register
  // --------------------------------------------------------------------------
  logic [6:0] usage_limit;
  logic       cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  assign prdata = (paddr[2] == abifc_pkg::REG_USAGE_LIMIT) ? {25'd0, usage_limit} : 32'd0;

  // --------------------------------------------------------------------------
  // Pacer state
  // --------------------------------------------------------------------------
  logic [6:0]  burst_limit, burst_limit_next;
  logic [5:0]  prev_link_count, prev_link_count_next;
  logic [6:0]  cur_burst, cur_burst_next;
  logic [15:0] cur_interval, cur_interval_next;
  logic [6:0]  peak_burst, peak_burst_next;
  logic [19:0] peak_msgs, peak_msgs_next;
  logic [15:0] best_interval, best_interval_next;
  logic [19:0] floor_msgs, floor_msgs_next;
  logic [31:0] time_last_inc, time_last_inc_next;
  logic [31:0] time_last_dec, time_last_dec_next;
  logic [31:0] time_last_overload, time_last_overload_next;
  logic [31:0] time_last_congest, time_last_congest_next;
  logic [31:0] time_last_yield, time_last_yield_next;
  abifc_pkg::action_t action_next;

  // Input stage
  logic              s1_valid;
  abifc_pkg::req_t   s1_req;
  logic [31:0]       s1_now;
  logic [19:0]       s1_sent;
  logic [6:0]        s1_usage;
  logic [5:0]        s1_links;

  // Result stage
  logic res_valid;
  logic advance;
  logic evt_acc;

  assign advance   = s1_valid && (!res_valid || res.ready);
  assign evt.ready = !s1_valid || advance;
  assign evt_acc   = evt.valid && evt.ready;
  assign res.valid = res_valid;

  // Hold-off check: signed elapsed time below the hold
  function automatic logic too_soon(input logic [31:0] now, input logic [31:0] last,
                                    input logic [31:0] hold);
    logic [31:0] d;
    d = now - last;
    return d[31] || (d < hold);
  endfunction

  // --------------------------------------------------------------------------
  // Fixed-point products (read state and the input stage, none chained)
  // --------------------------------------------------------------------------
  logic [32:0] up_prod;
  logic [31:0] dn_prod;
  logic [35:0] floor_prod;
  logic [16:0] up_val;
  logic [15:0] dn_val;
  logic [15:0] int_up, int_dn;
  logic [6:0]  burst_dn;
  logic [19:0] floor_src;
  logic [19:0] floor_val;
  logic [19:0] inc_peak;
  logic        new_peak;

  assign up_prod = 33'(cur_interval) * 33'(abifc_pkg::Q_UP);
  assign dn_prod = 32'(cur_interval) * 32'(abifc_pkg::Q_DOWN);
  assign up_val  = up_prod[32:16];
  assign dn_val  = dn_prod[31:16];

  assign int_up = (cur_interval >= abifc_pkg::MAX_INTERVAL) ? cur_interval :
                  (up_val > 17'(abifc_pkg::MAX_INTERVAL)) ? abifc_pkg::MAX_INTERVAL :
                  up_val[15:0];
  assign int_dn = (cur_interval <= abifc_pkg::MIN_INTERVAL) ? cur_interval :
                  (dn_val < abifc_pkg::MIN_INTERVAL) ? abifc_pkg::MIN_INTERVAL : dn_val;
  assign burst_dn = (cur_burst > abifc_pkg::MIN_BURST) ? cur_burst - 7'd1 : cur_burst;

  // Increase events take the floor of the updated peak, decreases of the old one
  assign new_peak   = s1_sent > peak_msgs;
  assign inc_peak   = new_peak ? s1_sent : peak_msgs;
  assign floor_src  = (s1_req == abifc_pkg::REQ_INC) ? inc_peak : peak_msgs;
  assign floor_prod = 36'(floor_src) * 36'(abifc_pkg::Q_FLOOR);
  assign floor_val  = floor_prod[35:16];

  // --------------------------------------------------------------------------
  // Load thresholds, unsigned form of the signed comparisons
  // --------------------------------------------------------------------------
  logic [7:0] u8, l8;
  logic       load_over, load_high, load_busy, load_near, load_low;

  assign u8        = {1'b0, s1_usage};
  assign l8        = {1'b0, usage_limit};
  assign load_over = u8 > (l8 + abifc_pkg::MARGIN_OVERLOAD);
  assign load_high = u8 > (l8 + abifc_pkg::MARGIN_HIGH);
  assign load_busy = (u8 + abifc_pkg::MARGIN_BUSY) >= l8;
  assign load_near = (u8 + abifc_pkg::MARGIN_NEAR) >= l8;
  assign load_low  = (u8 + abifc_pkg::MARGIN_YIELD) < l8;

  // --------------------------------------------------------------------------
  // Event evaluation
  // --------------------------------------------------------------------------
  logic [7:0] links_c;
  logic [5:0] links_n;

  assign links_c = ({2'b00, s1_links} > abifc_pkg::MAX_LINKS) ? abifc_pkg::MAX_LINKS
                                                              : {2'b00, s1_links};
  assign links_n = links_c[5:0];

  always_comb begin
    burst_limit_next        = burst_limit;
    prev_link_count_next    = prev_link_count;
    cur_burst_next          = cur_burst;
    cur_interval_next       = cur_interval;
    peak_burst_next         = peak_burst;
    peak_msgs_next          = peak_msgs;
    best_interval_next      = best_interval;
    floor_msgs_next         = floor_msgs;
    time_last_inc_next      = time_last_inc;
    time_last_dec_next      = time_last_dec;
    time_last_overload_next = time_last_overload;
    time_last_congest_next  = time_last_congest;
    time_last_yield_next    = time_last_yield;
    action_next             = abifc_pkg::ACT_NONE;

    unique case (s1_req)
      abifc_pkg::REQ_DEC: begin
        time_last_congest_next = s1_now;
        if (peak_burst >= cur_burst) begin
          if (peak_burst != 7'd0) peak_burst_next = peak_burst - 7'd1;
          peak_msgs_next = floor_val;
        end
        if (!too_soon(s1_now, time_last_dec, abifc_pkg::HOLD_DEC)) begin
          time_last_dec_next = s1_now;
          cur_burst_next     = burst_dn;
          cur_interval_next  = int_up;
          action_next        = abifc_pkg::ACT_DEC;
        end
      end

      abifc_pkg::REQ_INC: begin
        if (load_high && too_soon(s1_now, time_last_overload, abifc_pkg::HOLD_OVERLOAD)) begin
          // overload inside hold-off: only the increase time moves
          time_last_inc_next = s1_now;
        end else if (load_high) begin
          // overload handled; the fresh increase time then blocks the step
          time_last_inc_next      = s1_now;
          time_last_overload_next = s1_now;
          if (load_over) cur_burst_next    = burst_dn;
          else           cur_interval_next = int_up;
          if (new_peak) begin
            peak_msgs_next     = s1_sent;
            peak_burst_next    = load_over ? burst_dn : cur_burst;
            best_interval_next = load_over ? cur_interval : int_up;
          end
          floor_msgs_next = floor_val;
        end else begin
          if (new_peak) begin
            peak_msgs_next     = s1_sent;
            peak_burst_next    = cur_burst;
            best_interval_next = cur_interval;
          end
          floor_msgs_next = floor_val;
          if (!too_soon(s1_now, time_last_congest, abifc_pkg::HOLD_CONGEST) &&
              !too_soon(s1_now, time_last_inc, abifc_pkg::HOLD_INC) &&
              !load_busy &&
              !(cur_burst >= peak_burst_next && cur_interval <= best_interval_next &&
                s1_sent < floor_val)) begin
            time_last_inc_next = s1_now;
            action_next        = abifc_pkg::ACT_INC;
            if (load_near || cur_burst >= burst_limit) begin
              cur_interval_next = int_dn;
            end else begin
              cur_burst_next    = cur_burst + 7'd1;
              cur_interval_next = int_up;
            end
          end
        end
      end

      abifc_pkg::REQ_YIELD: begin
        if (!too_soon(s1_now, time_last_yield, abifc_pkg::HOLD_YIELD) && !load_low) begin
          time_last_yield_next = s1_now;
          cur_burst_next       = burst_dn;
          action_next          = abifc_pkg::ACT_YIELD;
        end
      end

      abifc_pkg::REQ_LINK: begin
        if (links_n != prev_link_count) begin
          prev_link_count_next = links_n;
          burst_limit_next     = 7'(links_n) + 7'(links_n >> 1);
          cur_burst_next       = (abifc_pkg::START_BURST > burst_limit_next) ?
                                 burst_limit_next : abifc_pkg::START_BURST;
          cur_interval_next    = abifc_pkg::START_INTERVAL;
          peak_burst_next      = 7'd0;
          best_interval_next   = abifc_pkg::MAX_INTERVAL;
          peak_msgs_next       = 20'd0;
        end
      end

      default: begin
        action_next = abifc_pkg::ACT_NONE;
      end
    endcase
  end

  // --------------------------------------------------------------------------
  // Control and state registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      usage_limit        <= abifc_pkg::USAGE_LIMIT_RST;
      s1_valid           <= 1'b0;
      res_valid          <= 1'b0;
      burst_limit        <= abifc_pkg::RESET_BURST_LIMIT;
      prev_link_count    <= 6'd0;
      cur_burst          <= abifc_pkg::START_BURST;
      cur_interval       <= abifc_pkg::START_INTERVAL;
      peak_burst         <= 7'd0;
      peak_msgs          <= 20'd0;
      best_interval      <= abifc_pkg::MAX_INTERVAL;
      floor_msgs         <= 20'd0;
      time_last_inc      <= 32'd0;
      time_last_dec      <= 32'd0;
      time_last_overload <= 32'd0;
      time_last_congest  <= 32'd0;
      time_last_yield    <= 32'd0;
    end else begin
      if (cfg_wr && paddr[2] == abifc_pkg::REG_USAGE_LIMIT) begin
        usage_limit <= pwdata[6:0];
      end

      if (evt_acc)      s1_valid <= 1'b1;
      else if (advance) s1_valid <= 1'b0;

      if (advance)        res_valid <= 1'b1;
      else if (res.ready) res_valid <= 1'b0;

      if (advance) begin
        burst_limit        <= burst_limit_next;
        prev_link_count    <= prev_link_count_next;
        cur_burst          <= cur_burst_next;
        cur_interval       <= cur_interval_next;
        peak_burst         <= peak_burst_next;
        peak_msgs          <= peak_msgs_next;
        best_interval      <= best_interval_next;
        floor_msgs         <= floor_msgs_next;
        time_last_inc      <= time_last_inc_next;
        time_last_dec      <= time_last_dec_next;
        time_last_overload <= time_last_overload_next;
        time_last_congest  <= time_last_congest_next;
        time_last_yield    <= time_last_yield_next;
      end
    end
  end

  // Input payload register
  always_ff @(posedge clk) begin
    if (evt_acc) begin
      s1_req   <= abifc_pkg::req_t'(evt.req_type);
      s1_now   <= evt.now_sec;
      s1_sent  <= evt.sent_count;
      s1_usage <= evt.load_pct;
      s1_links <= evt.active_links;
    end
  end

  // Result payload register
  always_ff @(posedge clk) begin
    if (advance) begin
      res.action         <= action_next;
      res.burst_size     <= cur_burst_next;
      res.burst_interval <= cur_interval_next;
      res.target_rate    <= floor_msgs_next;
      res.peak_rate      <= peak_msgs_next;
    end
  end

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_burst_in_limit: assert property (@(posedge clk) disable iff (rst)
    cur_burst <= burst_limit)
    else $error("burst above burst limit");

  a_interval_in_range: assert property (@(posedge clk) disable iff (rst)
    cur_interval >= abifc_pkg::MIN_INTERVAL && cur_interval <= abifc_pkg::MAX_INTERVAL)
    else $error("interval out of range");

  a_state_holds_on_stall: assert property (@(posedge clk) disable iff (rst)
    !advance |=> $stable(cur_burst) && $stable(cur_interval) && $stable(peak_msgs))
    else $error("pacer state changed without an event");

endmodule
`default_nettype wire

### bench/adaptive_burst_interval_flow_control_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adaptive_burst_interval_flow_control_test
// Self-checking bench for the send pacer. Events are pushed through the valid/ready
// event channel with random gaps, and the usage limit is set over the APB port
// between phases. A behavioral pacer computes the expected burst, interval and
// rate figures for each accepted event. The monitor checks every result
// transaction against the oldest pending expectation.
// ----------------------------------------------------------------------------
module adaptive_burst_interval_flow_control_test;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int PHASE_EVENTS = 240;

  typedef struct {
    abifc_pkg::req_t req;
    logic [31:0]     now;
    logic [19:0]     sent;
    logic [6:0]      usage;
    logic [5:0]      links;
  } pacer_event_t;

  typedef struct {
    abifc_pkg::action_t action;
    logic [6:0]         burst;
    logic [15:0]        interval;
    logic [19:0]        floor_rate;
    logic [19:0]        peak_rate;
  } pacer_result_t;

  logic        clk;
  logic        rst = 1'b1;
  logic        psel, penable, pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  abifc_evt_if evt();
  abifc_res_if res();

  adaptive_burst_interval_flow_control u_top (
    .clk     (clk),
    .rst     (rst),
    .evt     (evt),
    .res     (res),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // Bench bookkeeping
  pacer_event_t  pending_q[$];
  pacer_result_t outcome_q[$];
  int fail_count    = 0;
  int result_count  = 0;
  int cycle_count   = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;

  // Pacer mirror: configuration and state
  logic [6:0]  pm_usage_limit;
  logic [6:0]  pm_burst_cap;
  logic [5:0]  pm_links;
  logic [6:0]  pm_burst;
  logic [15:0] pm_interval;
  logic [6:0]  pm_peak_burst;
  logic [19:0] pm_peak_msgs;
  logic [15:0] pm_best_interval;
  logic [19:0] pm_floor_msgs;
  logic [31:0] pm_t_inc, pm_t_dec, pm_t_overload, pm_t_congest, pm_t_yield;

  function automatic void pacer_reset();
    pm_usage_limit   = abifc_pkg::USAGE_LIMIT_RST;
    pm_burst_cap     = abifc_pkg::RESET_BURST_LIMIT;
    pm_links         = '0;
    pm_burst         = abifc_pkg::START_BURST;
    pm_interval      = abifc_pkg::START_INTERVAL;
    pm_peak_burst    = '0;
    pm_peak_msgs     = '0;
    pm_best_interval = abifc_pkg::MAX_INTERVAL;
    pm_floor_msgs    = '0;
    pm_t_inc         = '0;
    pm_t_dec         = '0;
    pm_t_overload    = '0;
    pm_t_congest     = '0;
    pm_t_yield       = '0;
  endfunction

  // Elapsed time read as signed; negative or short counts as too soon
  function automatic bit too_soon(logic [31:0] now, logic [31:0] since, logic [31:0] hold);
    logic [31:0] d;
    d = now - since;
    return d[31] || (d < hold);
  endfunction

  // Q16 multiply, truncated
  function automatic logic [31:0] q16_scale(logic [31:0] v, logic [31:0] q);
    logic [63:0] p;
    p = 64'(v) * 64'(q);
    return p[47:16];
  endfunction

  function automatic void interval_up();
    logic [31:0] v;
    if (pm_interval < abifc_pkg::MAX_INTERVAL) begin
      v = q16_scale(32'(pm_interval), 32'(abifc_pkg::Q_UP));
      pm_interval = (v > 32'(abifc_pkg::MAX_INTERVAL)) ? abifc_pkg::MAX_INTERVAL : v[15:0];
    end
  endfunction

  function automatic void interval_down();
    logic [31:0] v;
    if (pm_interval > abifc_pkg::MIN_INTERVAL) begin
      v = q16_scale(32'(pm_interval), 32'(abifc_pkg::Q_DOWN));
      pm_interval = (v < 32'(abifc_pkg::MIN_INTERVAL)) ? abifc_pkg::MIN_INTERVAL : v[15:0];
    end
  endfunction

  function automatic void burst_down();
    if (pm_burst > abifc_pkg::MIN_BURST) pm_burst = pm_burst - 7'd1;
  endfunction

  function automatic abifc_pkg::action_t pace_decrease(logic [31:0] now);
    pm_t_congest = now;
    // peak burst saturates at zero
    if (pm_peak_burst >= pm_burst) begin
      if (pm_peak_burst != 0) pm_peak_burst = pm_peak_burst - 7'd1;
      pm_peak_msgs = 20'(q16_scale(32'(pm_peak_msgs), 32'(abifc_pkg::Q_FLOOR)));
    end
    if (too_soon(now, pm_t_dec, abifc_pkg::HOLD_DEC)) return abifc_pkg::ACT_NONE;
    pm_t_dec = now;
    burst_down();
    interval_up();
    return abifc_pkg::ACT_DEC;
  endfunction

  function automatic abifc_pkg::action_t pace_increase(logic [31:0] now, logic [19:0] sent,
                                                       int usage, int lim);
    // overload and high load back off first; state may move even if gated later
    if (usage > lim + int'(abifc_pkg::MARGIN_HIGH)) begin
      pm_t_inc = now;
      if (too_soon(now, pm_t_overload, abifc_pkg::HOLD_OVERLOAD)) return abifc_pkg::ACT_NONE;
      pm_t_overload = now;
      if (usage > lim + int'(abifc_pkg::MARGIN_OVERLOAD)) burst_down();
      else interval_up();
    end
    if (sent > pm_peak_msgs) begin
      pm_peak_msgs     = sent;
      pm_peak_burst    = pm_burst;
      pm_best_interval = pm_interval;
    end
    pm_floor_msgs = 20'(q16_scale(32'(pm_peak_msgs), 32'(abifc_pkg::Q_FLOOR)));

    if (too_soon(now, pm_t_congest, abifc_pkg::HOLD_CONGEST)) return abifc_pkg::ACT_NONE;
    if (too_soon(now, pm_t_inc, abifc_pkg::HOLD_INC)) return abifc_pkg::ACT_NONE;
    if (usage >= lim - int'(abifc_pkg::MARGIN_BUSY)) return abifc_pkg::ACT_NONE;
    if (pm_burst >= pm_peak_burst && pm_interval <= pm_best_interval &&
        sent < pm_floor_msgs) return abifc_pkg::ACT_NONE;

    pm_t_inc = now;
    if (usage >= lim - int'(abifc_pkg::MARGIN_NEAR)) begin
      interval_down();
    end else if (pm_burst >= pm_burst_cap) begin
      interval_down();
    end else begin
      pm_burst = pm_burst + 7'd1;
      interval_up();
    end
    return abifc_pkg::ACT_INC;
  endfunction

  function automatic abifc_pkg::action_t pace_yield(logic [31:0] now, int usage, int lim);
    if (too_soon(now, pm_t_yield, abifc_pkg::HOLD_YIELD)) return abifc_pkg::ACT_NONE;
    if (usage < lim - int'(abifc_pkg::MARGIN_YIELD)) return abifc_pkg::ACT_NONE;
    pm_t_yield = now;
    burst_down();
    return abifc_pkg::ACT_YIELD;
  endfunction

  // Link change: burst cap is 1.5x the count, pacing restarts, peaks clear.
  // A 6-bit count never exceeds the link clamp.
  function automatic void pace_relink(logic [5:0] n);
    if (n != pm_links) begin
      pm_links         = n;
      pm_burst_cap     = 7'(n) + 7'(n >> 1);
      pm_burst         = (abifc_pkg::START_BURST > pm_burst_cap) ? pm_burst_cap
                                                                 : abifc_pkg::START_BURST;
      pm_interval      = abifc_pkg::START_INTERVAL;
      pm_peak_burst    = '0;
      pm_best_interval = abifc_pkg::MAX_INTERVAL;
      pm_peak_msgs     = '0;
    end
  endfunction

  function automatic pacer_result_t pace_step(pacer_event_t e);
    pacer_result_t r;
    int usage;
    int lim;
    usage    = int'(e.usage);
    lim      = int'(pm_usage_limit);
    r.action = abifc_pkg::ACT_NONE;
    case (e.req)
      abifc_pkg::REQ_DEC:   r.action = pace_decrease(e.now);
      abifc_pkg::REQ_INC:   r.action = pace_increase(e.now, e.sent, usage, lim);
      abifc_pkg::REQ_YIELD: r.action = pace_yield(e.now, usage, lim);
      default:              pace_relink(e.links);
    endcase
    r.burst      = pm_burst;
    r.interval   = pm_interval;
    r.floor_rate = pm_floor_msgs;
    r.peak_rate  = pm_peak_msgs;
    return r;
  endfunction

  // Event driver: predicts each accepted transaction, then offers the next one
  always @(posedge clk) begin : event_driver
    pacer_event_t cur;
    pacer_event_t nxt;
    if (rst) begin
      evt.valid        <= 1'b0;
      evt.req_type     <= abifc_pkg::REQ_DEC;
      evt.now_sec      <= '0;
      evt.sent_count   <= '0;
      evt.load_pct     <= '0;
      evt.active_links <= '0;
    end else begin
      if (evt.valid && evt.ready) begin
        cur.req   = abifc_pkg::req_t'(evt.req_type);
        cur.now   = evt.now_sec;
        cur.sent  = evt.sent_count;
        cur.usage = evt.load_pct;
        cur.links = evt.active_links;
        outcome_q.push_back(pace_step(cur));
      end
      if (!evt.valid || evt.ready) begin
        if (pending_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          nxt = pending_q.pop_front();
          evt.valid        <= 1'b1;
          evt.req_type     <= nxt.req;
          evt.now_sec      <= nxt.now;
          evt.sent_count   <= nxt.sent;
          evt.load_pct     <= nxt.usage;
          evt.active_links <= nxt.links;
        end else begin
          evt.valid <= 1'b0;
        end
      end
    end
  end

  // Result ready: random stalls plus one long hold-off to back up the pipe
  int  hold_left = 0;
  bit  hold_done = 1'b0;
  always @(posedge clk) begin
    if (rst) begin
      res.ready <= 1'b0;
    end else if (hold_left != 0) begin
      res.ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (!hold_done && result_count >= 300) begin
      hold_done <= 1'b1;
      hold_left <= 400;
      res.ready <= 1'b0;
    end else begin
      res.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endfunction

  // Result monitor
  always @(posedge clk) begin : result_monitor
    pacer_result_t want;
    if (!rst && res.valid && res.ready) begin
      result_count <= result_count + 1;
      if (outcome_q.size() == 0) begin
        $error("result transaction with no pending event");
        fail_count++;
      end else begin
        want = outcome_q.pop_front();
        check_field("action", 32'(want.action), 32'(res.action));
        check_field("burst_size", 32'(want.burst), 32'(res.burst_size));
        check_field("burst_interval", 32'(want.interval), 32'(res.burst_interval));
        check_field("target_rate", 32'(want.floor_rate), 32'(res.target_rate));
        check_field("peak_rate", 32'(want.peak_rate), 32'(res.peak_rate));
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  function automatic pacer_event_t mk_event(abifc_pkg::req_t req, logic [31:0] now,
                                           logic [19:0] sent, logic [6:0] usage,
                                           logic [5:0] links);
    pacer_event_t e;
    e.req   = req;
    e.now   = now;
    e.sent  = sent;
    e.usage = usage;
    e.links = links;
    return e;
  endfunction

  // APB write: setup then access phase
  task automatic write_usage_limit(logic [6:0] v);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {abifc_pkg::REG_USAGE_LIMIT, 2'b00};
    pwdata  <= 32'(v);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    pm_usage_limit = v;
  endtask

  // Wait until no transaction is queued, offered or outstanding, plus pipe latency
  task automatic drain();
    @(negedge clk);
    while (pending_q.size() != 0 || evt.valid || outcome_q.size() != 0) @(negedge clk);
    repeat (4) @(posedge clk);
  endtask

  logic [31:0] gen_sec   = 32'd1000;
  logic [5:0]  gen_links = 6'd8;
  int          gen_level = 500;

  // Random events: mostly a forward-moving clock with load near the limit
  task automatic queue_random(int n);
    pacer_event_t e;
    int r;
    int u;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      if (r < 75)      gen_sec = gen_sec + $urandom_range(0, 9);
      else if (r < 90) gen_sec = gen_sec + $urandom_range(10, 40);
      else if (r < 95) gen_sec = $urandom();
      else             gen_sec = gen_sec - $urandom_range(1, 20);

      r = $urandom_range(0, 99);
      if (r < 58)      e.req = abifc_pkg::REQ_INC;
      else if (r < 73) e.req = abifc_pkg::REQ_DEC;
      else if (r < 97) e.req = abifc_pkg::REQ_YIELD;
      else             e.req = abifc_pkg::REQ_LINK;

      if ($urandom_range(0, 99) < 70) begin
        u = int'(pm_usage_limit) + int'($urandom_range(0, 22)) - 12;
        if (u < 0) u = 0;
        if (u > 127) u = 127;
      end else begin
        u = $urandom_range(0, 127);
      end

      if (gen_level < 800000) gen_level = gen_level + $urandom_range(0, 60);
      if ($urandom_range(0, 99) < 20) e.sent = 20'($urandom());
      else e.sent = 20'(gen_level / 2 + $urandom_range(0, gen_level * 3 / 4));

      if (e.req == abifc_pkg::REQ_LINK && $urandom_range(0, 1) == 1) begin
        gen_links = 6'($urandom_range(0, 63));
        gen_level = 500;
      end
      e.links = (e.req == abifc_pkg::REQ_LINK) ? gen_links : 6'($urandom());
      e.now   = gen_sec;
      e.usage = 7'(u);
      pending_q.push_back(e);
    end
  endtask

  initial begin : stimulus
    logic [6:0] phase_limit [6];
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= '0;
    pwdata  <= '0;
    phase_limit = '{7'd100, 7'd0, 7'd127, 7'($urandom_range(0, 127)), 7'd80,
                    7'($urandom_range(0, 127))};
    pacer_reset();
    rst <= 1'b1;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Directed: reset limit of 80
    pending_q.push_back(mk_event(abifc_pkg::REQ_LINK, 32'd0, 20'd0, 7'd0, 6'd63));
    pending_q.push_back(mk_event(abifc_pkg::REQ_INC, 32'd100, 20'hFFFFF, 7'd0, 6'd0));
    // overload lowers the burst, then the increase hold-off gates it
    pending_q.push_back(mk_event(abifc_pkg::REQ_INC, 32'd101, 20'd0, 7'd127, 6'd0));
    pending_q.push_back(mk_event(abifc_pkg::REQ_INC, 32'd103, 20'd0, 7'd84, 6'd0));
    pending_q.push_back(mk_event(abifc_pkg::REQ_INC, 32'd110, 20'd0, 7'd84, 6'd0));
    pending_q.push_back(mk_event(abifc_pkg::REQ_DEC, 32'd120, 20'd0, 7'd50, 6'd0));
    pending_q.push_back(mk_event(abifc_pkg::REQ_DEC, 32'd121, 20'd0, 7'd50, 6'd0));
    pending_q.push_back(mk_event(abifc_pkg::REQ_YIELD, 32'd130, 20'd0, 7'd70, 6'd0));
    pending_q.push_back(mk_event(abifc_pkg::REQ_YIELD, 32'd135, 20'd0, 7'd100, 6'd0));
    pending_q.push_back(mk_event(abifc_pkg::REQ_YIELD, 32'd150, 20'd0, 7'd69, 6'd0));
    pending_q.push_back(mk_event(abifc_pkg::REQ_INC, 32'd200, 20'hFFFFF, 7'd75, 6'd0));
    pending_q.push_back(mk_event(abifc_pkg::REQ_INC, 32'd300, 20'hFFFFF, 7'd50, 6'd0));
    // one link: burst clamps to the cap, increase falls back to a shorter interval
    pending_q.push_back(mk_event(abifc_pkg::REQ_LINK, 32'd310, 20'd0, 7'd0, 6'd1));
    pending_q.push_back(mk_event(abifc_pkg::REQ_INC, 32'd400, 20'hFFFFF, 7'd0, 6'd0));
    pending_q.push_back(mk_event(abifc_pkg::REQ_DEC, 32'd410, 20'd0, 7'd0, 6'd0));
    // zero links, then decrease with the peak burst already at zero
    pending_q.push_back(mk_event(abifc_pkg::REQ_LINK, 32'd420, 20'd0, 7'd0, 6'd0));
    pending_q.push_back(mk_event(abifc_pkg::REQ_DEC, 32'd430, 20'd0, 7'd0, 6'd0));
    // timestamp wrap, time running backwards, half-range difference
    pending_q.push_back(mk_event(abifc_pkg::REQ_INC, 32'hFFFF_FFF8, 20'hFFFFF, 7'd0, 6'd63));
    pending_q.push_back(mk_event(abifc_pkg::REQ_INC, 32'h0000_0010, 20'hAAAAA, 7'd0, 6'd0));
    pending_q.push_back(mk_event(abifc_pkg::REQ_YIELD, 32'h0000_0005, 20'h55555, 7'd127,
                                 6'd0));
    pending_q.push_back(mk_event(abifc_pkg::REQ_DEC, 32'h8000_01AE, 20'd0, 7'd0, 6'd0));
    pending_q.push_back(mk_event(abifc_pkg::REQ_LINK, 32'h8000_01B0, 20'd0, 7'd0, 6'd42));
    pending_q.push_back(mk_event(abifc_pkg::REQ_LINK, 32'h8000_01B1, 20'd0, 7'd0, 6'd21));

    for (int p = 0; p < 6; p++) begin
      drain();
      if (p < 2) begin
        send_idle_pct = 24;
        recv_idle_pct = 57;
      end else if (p < 4) begin
        send_idle_pct = 57;
        recv_idle_pct = 24;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      write_usage_limit(phase_limit[p]);
      queue_random(PHASE_EVENTS);
    end

    drain();
    repeat (6) @(posedge clk);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/core/abifc_pkg.sv
rtl/core/abifc_if.sv
rtl/core/adaptive_burst_interval_flow_control.sv
bench/adaptive_burst_interval_flow_control_test.sv
